// ===== sv/itaf_pkg.sv =====
// Package for the integer to ASCII formatter.
// Holds the character codes, the power-of-ten table, the nibble encoder and the state type.
// Depends on nothing.
package itaf_pkg;

	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_MINUS   = 7'h2D;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [1:0] MODE_UNSIGNED = 2'd0;
	localparam logic [1:0] MODE_SIGNED   = 2'd1;
	localparam logic [1:0] MODE_HEX      = 2'd2;

	// Index of the units position, which follows the nine powers of ten.
	localparam logic [3:0] UNITS_IDX = 4'd9;
	localparam logic [3:0] MAX_HEX   = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUB  = 4'b0010,
		ST_HEX  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// Powers of ten from 10^9 down to 10.
	function automatic logic [31:0] decade(input logic [3:0] idx);
		logic [31:0] d;
		unique case (idx)
			4'd0: d = 32'd1000000000;
			4'd1: d = 32'd100000000;
			4'd2: d = 32'd10000000;
			4'd3: d = 32'd1000000;
			4'd4: d = 32'd100000;
			4'd5: d = 32'd10000;
			4'd6: d = 32'd1000;
			4'd7: d = 32'd100;
			4'd8: d = 32'd10;
			default: d = 32'd1;
		endcase
		return d;
	endfunction

	function automatic logic [6:0] nibble_char(input logic [3:0] v);
		logic [3:0] n;
		logic [6:0] c;
		n = v & NIBBLE_MASK;
		if (n < 4'd10) begin
			c = CH_ZERO + {3'd0, n};
		end else begin
			c = CH_UPPER_A + {3'd0, n - 4'd10};
		end
		return c;
	endfunction

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
// Uses itaf_pkg for character codes, the power-of-ten table and the state type.
//
// Formats one 32-bit value per input item as ASCII, one character per output item,
// most significant first, with last set on the final character. Decimal modes use a
// single 32-bit compare and subtract unit that works down the powers of ten from 10^9,
// one subtraction per cycle while no character waits to be taken; a digit d above the
// units takes d subtractions and then a failed compare before its character is handed
// out, and a suppressed leading zero hands out nothing. Hex mode encodes each character
// in ST_HEX and hands it out in ST_OUT. The input is not ready until the final character
// of the current number has been taken.
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] value,
	input  logic [3:0]  hex_digits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  character,
	output logic        last
);

	itaf_pkg::state_t state_q;
	logic [31:0] val_q;
	logic [3:0]  idx_q;
	logic [3:0]  digit_q;
	logic [3:0]  cnt_q;
	logic        started_q;
	logic        hex_q;
	logic [6:0]  char_q;
	logic        last_q;

	logic [31:0] dec;
	logic        ge;
	logic [3:0]  ncnt;
	logic [2:0]  pad;
	logic [4:0]  shamt;
	logic        neg;

	assign in_ready  = (state_q == itaf_pkg::ST_IDLE);
	assign out_valid = (state_q == itaf_pkg::ST_OUT);
	assign character = char_q;
	assign last      = last_q;

	assign dec = itaf_pkg::decade(idx_q);
	assign ge  = (val_q >= dec);
	assign neg = (mode == itaf_pkg::MODE_SIGNED) && value[31];

	always_comb begin
		if (hex_digits == 4'd0) begin
			ncnt = 4'd1;
		end else if (hex_digits > itaf_pkg::MAX_HEX) begin
			ncnt = itaf_pkg::MAX_HEX;
		end else begin
			ncnt = hex_digits;
		end
		// Align the top printed nibble to bits 31:28.
		pad   = 3'(itaf_pkg::MAX_HEX - ncnt);
		shamt = {pad, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itaf_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				itaf_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (mode == itaf_pkg::MODE_HEX) begin
							state_q <= itaf_pkg::ST_HEX;
						end else if (neg) begin
							state_q <= itaf_pkg::ST_OUT;
						end else begin
							state_q <= itaf_pkg::ST_SUB;
						end
					end
				end
				itaf_pkg::ST_SUB: begin
					if (idx_q == itaf_pkg::UNITS_IDX) begin
						state_q <= itaf_pkg::ST_OUT;
					end else if (!ge && (digit_q != 4'd0 || started_q)) begin
						state_q <= itaf_pkg::ST_OUT;
					end
				end
				itaf_pkg::ST_HEX: begin
					state_q <= itaf_pkg::ST_OUT;
				end
				itaf_pkg::ST_OUT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= itaf_pkg::ST_IDLE;
						end else if (hex_q) begin
							state_q <= itaf_pkg::ST_HEX;
						end else begin
							state_q <= itaf_pkg::ST_SUB;
						end
					end
				end
				default: state_q <= itaf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			itaf_pkg::ST_IDLE: begin
				idx_q     <= 4'd0;
				digit_q   <= 4'd0;
				started_q <= 1'b0;
				cnt_q     <= ncnt;
				hex_q     <= (mode == itaf_pkg::MODE_HEX);
				char_q    <= itaf_pkg::CH_MINUS;
				last_q    <= 1'b0;
				if (mode == itaf_pkg::MODE_HEX) begin
					val_q <= value << shamt;
				end else if (neg) begin
					val_q <= 32'd0 - value;
				end else begin
					val_q <= value;
				end
			end
			itaf_pkg::ST_SUB: begin
				if (idx_q == itaf_pkg::UNITS_IDX) begin
					// The remainder is the units digit, always printed.
					char_q <= itaf_pkg::CH_ZERO + {3'd0, val_q[3:0]};
					last_q <= 1'b1;
				end else if (ge) begin
					val_q   <= val_q - dec;
					digit_q <= digit_q + 4'd1;
				end else begin
					if (digit_q != 4'd0 || started_q) begin
						char_q    <= itaf_pkg::CH_ZERO + {3'd0, digit_q};
						started_q <= 1'b1;
					end
					digit_q <= 4'd0;
					idx_q   <= idx_q + 4'd1;
				end
			end
			itaf_pkg::ST_HEX: begin
				char_q <= itaf_pkg::nibble_char(val_q[31:28]);
				last_q <= (cnt_q == 4'd1);
				val_q  <= val_q << 4;
				cnt_q  <= cnt_q - 4'd1;
			end
			itaf_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_formatter: predicts each character string
// from the input item, compares it against the block's output stream. Depends on itaf_pkg.
module tb_top;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [6:0] character;
		logic       last;
	} ascii_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = itaf_pkg::MODE_UNSIGNED;
	logic [31:0] value = '0;
	logic [3:0]  hex_digits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  character;
	logic        last;

	ascii_char_t pending_chars[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	integer_to_ascii_formatter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.value      (value),
		.hex_digits (hex_digits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Works out the characters of one number. Decimal digits come from division here,
	// so the check does not lean on the block's own subtraction scheme.
	function automatic void predict_characters(input logic [1:0] m, input logic [31:0] v,
			input logic [3:0] h);
		logic [6:0]  digits_q[$];
		logic [31:0] rest;
		logic [3:0]  nib;
		int          count;
		ascii_char_t c;

		if (m == itaf_pkg::MODE_HEX) begin
			count = h;
			if (count < 1) count = 1;
			if (count > itaf_pkg::MAX_HEX) count = itaf_pkg::MAX_HEX;
			for (int k = count; k > 0; k--) begin
				nib = 4'((v >> ((k - 1) * 4)) & 32'hF);
				if (nib < 4'd10) begin
					digits_q.push_back(itaf_pkg::CH_ZERO + 7'(nib));
				end else begin
					digits_q.push_back(itaf_pkg::CH_UPPER_A + 7'(nib - 4'd10));
				end
			end
		end else begin
			rest = v;
			if (m == itaf_pkg::MODE_SIGNED && v[31]) begin
				c.character = itaf_pkg::CH_MINUS;
				c.last = 1'b0;
				pending_chars.push_back(c);
				rest = -v;
			end
			do begin
				digits_q.push_front(itaf_pkg::CH_ZERO + 7'(rest % 10));
				rest = rest / 10;
			end while (rest != 0);
		end
		foreach (digits_q[i]) begin
			c.character = digits_q[i];
			c.last = (i == digits_q.size() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		ascii_char_t exp_c;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character %h with no item pending", character);
				mismatch_count++;
			end else begin
				exp_c = pending_chars.pop_front();
				if (character !== exp_c.character) begin
					$error("character: expected %h, got %h", exp_c.character, character);
					mismatch_count++;
				end
				if (last !== exp_c.last) begin
					$error("last: expected %b, got %b", exp_c.last, last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_item(input logic [1:0] m, input logic [31:0] v, input logic [3:0] h);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		hex_digits <= h;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_characters(m, v, h);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_unsigned_decimal();
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd0, 4'd0);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd1, 4'd0);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd9, 4'd15);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd10, 4'd0);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd999999999, 4'd0);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd1000000000, 4'd0);
		send_item(itaf_pkg::MODE_UNSIGNED, 32'hFFFF_FFFF, 4'd0);
		// The spare mode code formats like unsigned decimal.
		send_item(MODE_SPARE, 32'd12345, 4'd0);
		send_item(MODE_SPARE, 32'hFFFF_FFFF, 4'd7);
	endtask

	task automatic test_signed_decimal();
		send_item(itaf_pkg::MODE_SIGNED, 32'd0, 4'd0);
		send_item(itaf_pkg::MODE_SIGNED, 32'd1, 4'd0);
		send_item(itaf_pkg::MODE_SIGNED, 32'hFFFF_FFFF, 4'd0);
		send_item(itaf_pkg::MODE_SIGNED, 32'h8000_0000, 4'd0);
		send_item(itaf_pkg::MODE_SIGNED, 32'h7FFF_FFFF, 4'd0);
		send_item(itaf_pkg::MODE_SIGNED, -32'sd10, 4'd0);
	endtask

	task automatic test_hex_digits();
		send_item(itaf_pkg::MODE_HEX, 32'hFEDC_BA98, 4'd0);
		send_item(itaf_pkg::MODE_HEX, 32'h0123_4567, 4'd1);
		send_item(itaf_pkg::MODE_HEX, 32'h89AB_CDEF, 4'd8);
		send_item(itaf_pkg::MODE_HEX, 32'hFEDC_BA98, 4'd9);
		send_item(itaf_pkg::MODE_HEX, 32'h0000_0000, 4'd15);
		send_item(itaf_pkg::MODE_HEX, 32'h00AB_CDEF, 4'd5);
	endtask

	task automatic test_drain_pause();
		send_item(itaf_pkg::MODE_SIGNED, 32'h8000_0000, 4'd0);
		send_item(itaf_pkg::MODE_HEX, 32'hA5A5_5A5A, 4'd8);
		wait_for_drain();
		send_item(itaf_pkg::MODE_UNSIGNED, 32'd4000000000, 4'd0);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] p;
		p = 32'd1;
		unique case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 999);
			2: begin
				repeat ($urandom_range(1, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			3: return -$urandom_range(1, 1000);
			4: unique case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		logic [1:0] m;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			// The spare mode code shows up now and then; the rest is spread evenly.
			m = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
			send_item(m, random_operand(), 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsigned_decimal();
		test_signed_decimal();
		test_hex_digits();
		test_drain_pause();
		test_random_traffic(20, 0, 0);
		test_random_traffic(20, 52, 0);
		test_random_traffic(20, 0, 52);
		test_random_traffic(20, 11, 11);

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
